@@ src/fst_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fst_pkg;

  // store geometry
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned OCNT_W   = 5;

  // command codes, code 3 behaves as a query
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_e;

  // result status codes
  typedef enum logic [1:0] {
    STAT_DONE   = 2'd0,
    STAT_DUP    = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_ABSENT = 2'd3
  } status_e;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SEARCH = 2'd1,
    S_SHIFT  = 2'd2
  } state_e;

  // commands broadcast to every cell of the row
  typedef struct packed {
    logic start;  // place the token on the first cell
    logic adv;    // hand the token one cell up
    logic wr;     // token cell loads the key
    logic shift;  // token cell loads its upper neighbour
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ src/fst_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fst_cell import fst_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cell_ctl_t        ctl_i,
  input  wire logic             first_i,       // high on the lowest cell only
  input  wire logic             tok_prev_i,    // token of the lower neighbour
  input  wire logic [VAL_W-1:0] key_i,
  input  wire logic [VAL_W-1:0] next_elem_i,   // element of the upper neighbour
  output logic                  tok_o,
  output logic      [VAL_W-1:0] elem_o,
  output logic                  hit_o
);

  logic             tok_q, tok_d;
  logic [VAL_W-1:0] elem_q, elem_d;

  // token walks up the row one cell a cycle
  always_comb begin
    tok_d = tok_q;
    if (ctl_i.start) begin
      tok_d = first_i;
    end else if (ctl_i.adv) begin
      tok_d = tok_prev_i;
    end
  end

  // element update happens only where the token sits
  always_comb begin
    elem_d = elem_q;
    if (tok_q && ctl_i.wr) begin
      elem_d = key_i;
    end else if (tok_q && ctl_i.shift) begin
      elem_d = next_elem_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    elem_q <= elem_d;
  end

  // compare only under the token
  assign hit_o  = tok_q && (elem_q == key_i);
  assign tok_o  = tok_q;
  assign elem_o = elem_q;

endmodule

`default_nettype wire

@@ src/fst_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fst_ctrl import fst_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_valid_i,
  output logic                   s_ready_o,
  input  wire logic [CMD_W-1:0]  cmd_i,
  input  wire logic [VAL_W-1:0]  value_i,
  input  wire logic              hit_i,
  output cell_ctl_t              ctl_o,
  output logic      [VAL_W-1:0]  key_o,
  output logic                   m_valid_o,
  input  wire logic              m_ready_i,
  output logic                   was_member_o,
  output logic      [OCNT_W-1:0] count_o,
  output logic      [1:0]        status_o
);

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    pos_q, pos_d;
  logic [CMD_W-1:0]    cmd_q;
  logic [VAL_W-1:0]    key_q;
  logic                m_valid_q, m_valid_d;
  logic                member_q;
  logic [OCNT_W-1:0]   rcount_q;
  status_e             status_q;

  logic                out_free;
  logic                at_end;
  logic                last_slot;
  logic                fin;
  logic                pos_inc;
  logic                res_member;
  status_e             res_status;

  assign out_free  = !m_valid_q || m_ready_i;
  assign at_end    = (pos_q == count_q);
  assign last_slot = (pos_q == (count_q - CNT_W'(1)));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_valid_i) state_d = S_SEARCH;
      end
      S_SEARCH: begin
        if (at_end) begin
          if (out_free) state_d = S_IDLE;
        end else if (hit_i) begin
          if (cmd_q == CMD_REMOVE) begin
            state_d = S_SHIFT;
          end else if (out_free) begin
            state_d = S_IDLE;
          end
        end
      end
      S_SHIFT: begin
        if (last_slot && out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // cell commands and result
  always_comb begin
    s_ready_o  = 1'b0;
    ctl_o      = '0;
    fin        = 1'b0;
    pos_inc    = 1'b0;
    res_member = 1'b0;
    res_status = STAT_DONE;
    count_d    = count_q;
    case (state_q)
      S_IDLE: begin
        s_ready_o   = 1'b1;
        ctl_o.start = s_valid_i;
      end
      S_SEARCH: begin
        if (at_end) begin
          // value absent, token sits on the first free slot
          if (out_free) begin
            fin = 1'b1;
            if (cmd_q == CMD_INSERT) begin
              if (count_q < CNT_W'(CAPACITY)) begin
                ctl_o.wr = 1'b1;
                count_d  = count_q + CNT_W'(1);
              end else begin
                res_status = STAT_FULL;
              end
            end else if (cmd_q == CMD_REMOVE) begin
              res_status = STAT_ABSENT;
            end
          end
        end else if (hit_i) begin
          // remove goes on to close the gap from this slot
          if ((cmd_q != CMD_REMOVE) && out_free) begin
            fin        = 1'b1;
            res_member = 1'b1;
            if (cmd_q == CMD_INSERT) res_status = STAT_DUP;
          end
        end else begin
          ctl_o.adv = 1'b1;
          pos_inc   = 1'b1;
        end
      end
      S_SHIFT: begin
        if (last_slot) begin
          if (out_free) begin
            fin        = 1'b1;
            res_member = 1'b1;
            count_d    = count_q - CNT_W'(1);
          end
        end else begin
          ctl_o.shift = 1'b1;
          ctl_o.adv   = 1'b1;
          pos_inc     = 1'b1;
        end
      end
      default: begin
        s_ready_o = 1'b0;
      end
    endcase
  end

  // position of the token
  always_comb begin
    pos_d = pos_q;
    if (ctl_o.start) begin
      pos_d = '0;
    end else if (pos_inc) begin
      pos_d = pos_q + CNT_W'(1);
    end
  end

  // output word register
  always_comb begin
    m_valid_d = m_valid_q;
    if (fin) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      pos_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      pos_q     <= pos_d;
      m_valid_q <= m_valid_d;
    end
  end

  // command capture and result payload
  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      cmd_q <= cmd_i;
      key_q <= value_i;
    end
    if (fin) begin
      member_q <= res_member;
      rcount_q <= OCNT_W'(count_d);
      status_q <= res_status;
    end
  end

  assign key_o        = key_q;
  assign m_valid_o    = m_valid_q;
  assign was_member_o = member_q;
  assign count_o      = rcount_q;
  assign status_o     = status_q;

endmodule

`default_nettype wire

@@ src/fixed_capacity_set_table.sv @@
// Set of up to 16 distinct 32-bit values held in a row of cells.
// Input stream: one word per command, tuser carries the command (0 insert,
// 1 remove, 2 query) and tdata the value. Output stream: one word per
// command with was_member, the count after the command and a status.
// A command is taken only while the block is idle. A search token walks
// up the cell row one slot a cycle; a remove keeps walking the token from
// the matching slot up to the last stored slot, each cell copying its
// upper neighbour. The result is registered once the token reaches
// the matching slot for a value found (insert, query), reaches the first
// free slot for an absent value, or reaches the last stored slot for a
// successful remove; the next command can be taken in the cycle after
// the result is registered. The token walk is what sets the rate.
// Reset empties the set (count zero) and leaves the output idle; slot
// contents are not cleared. If the receiver stalls, the finished word
// holds in the output register and the next command runs up to its
// result, where it waits until the output register frees.
`timescale 1ns / 1ps
`default_nettype none

module fixed_capacity_set_table import fst_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire logic [VAL_W-1:0]      s_axis_tdata_i,   // [31:0] value
  input  wire logic [CMD_W-1:0]      s_axis_tuser_i,   // [1:0] cmd
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  output logic      [7:0]            m_axis_tdata_o    // [0] was_member, [5:1] count,
                                                       // [7:6] status
);

  cell_ctl_t               ctl;
  logic [VAL_W-1:0]        key;
  logic [CAPACITY-1:0]     tok;
  logic [CAPACITY-1:0]     hit;
  logic [VAL_W-1:0]        elem [CAPACITY];
  logic                    was_member;
  logic [OCNT_W-1:0]       count;
  logic [1:0]              status;

  // sequencer and output register
  fst_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid_i),
    .s_ready_o    (s_axis_tready_o),
    .cmd_i        (s_axis_tuser_i),
    .value_i      (s_axis_tdata_i),
    .hit_i        (|hit),
    .ctl_o        (ctl),
    .key_o        (key),
    .m_valid_o    (m_axis_tvalid_o),
    .m_ready_i    (m_axis_tready_i),
    .was_member_o (was_member),
    .count_o      (count),
    .status_o     (status)
  );

  // row of storage cells, token enters at the bottom
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    fst_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .first_i     (1'(i == 0)),
      .tok_prev_i  ((i == 0) ? 1'b0 : tok[(i == 0) ? 0 : i-1]),
      .key_i       (key),
      .next_elem_i (elem[(i == CAPACITY-1) ? i : i+1]),
      .tok_o       (tok[i]),
      .elem_o      (elem[i]),
      .hit_o       (hit[i])
    );
  end

  assign m_axis_tdata_o = {status, count, was_member};

endmodule

`default_nettype wire

@@ tb/sv/fixed_capacity_set_table_test.sv @@
`timescale 1ns / 1ps

module fixed_capacity_set_table_test;
  import fst_pkg::*;

  // unused command code, the block treats it as a query
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  localparam int unsigned RANDOM_CMDS = 2000;
  localparam int unsigned POOL_SIZE   = 22;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_WAIT  = 40;
  localparam int unsigned IDLE_PCT    = 19;
  localparam int unsigned STEADY_LO   = 15000;
  localparam int unsigned STEADY_HI   = 25000;

  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic [VAL_W-1:0] val;
  } set_cmd_t;

  typedef struct packed {
    logic              was_member;
    logic [OCNT_W-1:0] count;
    status_e           status;
  } set_result_t;

  logic              clk     = 1'b0;
  logic              rst_n   = 1'b0;
  logic              s_valid = 1'b0;
  logic [VAL_W-1:0]  s_value = '0;
  logic [CMD_W-1:0]  s_op    = CMD_INSERT;
  logic              s_ready;
  logic              m_valid;
  logic              m_ready = 1'b0;
  logic [7:0]        m_word;

  set_cmd_t          pending_cmds[$];
  set_result_t       results_due[$];

  // shadow copy of the set
  logic [VAL_W-1:0]  held_vals [CAPACITY];
  int unsigned       held_cnt = 0;

  int unsigned       cycle_cnt = 0;
  int unsigned       fail_cnt  = 0;
  int unsigned       cmds_taken = 0;
  int unsigned       results_seen = 0;
  int unsigned       status_tally [4] = '{0, 0, 0, 0};
  int unsigned       peak_cnt = 0;

  logic [VAL_W-1:0]  val_pool [POOL_SIZE];

  fixed_capacity_set_table u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_value),
    .s_axis_tuser_i  (s_op),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_word)
  );

  // clock
  always #5 clk = ~clk;

  // random idling, switched off in one long window
  function automatic bit idle_now();
    bit steady;
    steady = (cycle_cnt >= STEADY_LO) && (cycle_cnt < STEADY_HI);
    return !steady && ($urandom_range(99) < IDLE_PCT);
  endfunction

  // apply one command to the shadow set and return its result word
  function automatic set_result_t apply_set_cmd(logic [CMD_W-1:0] op, logic [VAL_W-1:0] v);
    set_result_t r;
    int unsigned slot;
    slot = held_cnt;
    for (int unsigned i = 0; i < held_cnt; i++) begin
      if (slot == held_cnt && held_vals[i] == v) begin
        slot = i;
      end
    end
    r.was_member = (slot < held_cnt);
    r.status     = STAT_DONE;
    if (op == CMD_INSERT) begin
      if (r.was_member) begin
        r.status = STAT_DUP;
      end else if (held_cnt >= CAPACITY) begin
        r.status = STAT_FULL;
      end else begin
        held_vals[held_cnt] = v;
        held_cnt++;
      end
    end else if (op == CMD_REMOVE) begin
      if (!r.was_member) begin
        r.status = STAT_ABSENT;
      end else begin
        for (int unsigned j = slot + 1; j < held_cnt; j++) begin
          held_vals[j-1] = held_vals[j];
        end
        held_cnt--;
      end
    end
    r.count = OCNT_W'(held_cnt);
    return r;
  endfunction

  task automatic push_cmd(logic [CMD_W-1:0] op, logic [VAL_W-1:0] v);
    set_cmd_t c;
    c.op  = op;
    c.val = v;
    pending_cmds.push_back(c);
  endtask

  // cycle counter and watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("fixed_capacity_set_table_test failed");
      $finish;
    end
  end

  // command driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (!s_valid || s_ready) begin
        if (pending_cmds.size() != 0 && !idle_now()) begin
          s_op    <= pending_cmds[0].op;
          s_value <= pending_cmds[0].val;
          s_valid <= 1'b1;
          void'(pending_cmds.pop_front());
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // result sink stalls
  always @(posedge clk) begin
    if (rst_n) begin
      m_ready <= !idle_now();
    end
  end

  // prediction on accepted commands, checking on accepted results
  always @(posedge clk) begin
    set_result_t due;
    if (rst_n) begin
      if (s_valid && s_ready) begin
        results_due.push_back(apply_set_cmd(s_op, s_value));
        cmds_taken++;
        if (held_cnt > peak_cnt) begin
          peak_cnt = held_cnt;
        end
      end
      if (m_valid && m_ready) begin
        results_seen++;
        if (results_due.size() == 0) begin
          $error("result word 0x%02h with no command outstanding", m_word);
          fail_cnt++;
        end else begin
          due = results_due.pop_front();
          status_tally[due.status]++;
          if (m_word[0] !== due.was_member) begin
            $error("was_member: expected %0d, got %0d", due.was_member, m_word[0]);
            fail_cnt++;
          end
          if (m_word[5:1] !== due.count) begin
            $error("count: expected %0d, got %0d", due.count, m_word[5:1]);
            fail_cnt++;
          end
          if (m_word[7:6] !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, m_word[7:6]);
            fail_cnt++;
          end
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    bit insert_heavy;
    int unsigned pick;
    logic [CMD_W-1:0] op;
    logic [VAL_W-1:0] v;

    // directed: empty set, extremes, fill to capacity, corner commands
    push_cmd(CMD_QUERY, 32'h8000_0000);
    push_cmd(CMD_REMOVE, 32'h0000_0000);
    push_cmd(CMD_INSERT, 32'h8000_0000);
    push_cmd(CMD_INSERT, 32'h7FFF_FFFF);
    push_cmd(CMD_INSERT, 32'h0000_0000);
    push_cmd(CMD_INSERT, 32'hFFFF_FFFF);
    push_cmd(CMD_INSERT, 32'h5555_5555);
    for (int i = 0; i < 11; i++) begin
      push_cmd(CMD_INSERT, 32'h1357_0000 + i);
    end
    // duplicate, full store, spare code, removes at middle, end and start
    push_cmd(CMD_INSERT, 32'h7FFF_FFFF);
    push_cmd(CMD_INSERT, 32'hAAAA_AAAA);
    push_cmd(CMD_SPARE, 32'h8000_0000);
    push_cmd(CMD_REMOVE, 32'h1357_0003);
    push_cmd(CMD_REMOVE, 32'h1357_000A);
    push_cmd(CMD_REMOVE, 32'h8000_0000);

    // random: values mostly from a small pool so the set fills and empties
    val_pool[0] = 32'h8000_0000;
    val_pool[1] = 32'h7FFF_FFFF;
    val_pool[2] = 32'h0000_0000;
    val_pool[3] = 32'hFFFF_FFFF;
    insert_heavy = 1'b1;
    for (int unsigned n = 0; n < RANDOM_CMDS; n++) begin
      if (n % 250 == 0) begin
        for (int unsigned p = 4; p < POOL_SIZE; p++) begin
          val_pool[p] = $urandom;
        end
      end
      if (n % 60 == 0) begin
        insert_heavy = 1'($urandom_range(1));
      end
      pick = $urandom_range(99);
      if (insert_heavy) begin
        op = (pick < 55) ? CMD_INSERT : (pick < 75) ? CMD_REMOVE :
             (pick < 95) ? CMD_QUERY : CMD_SPARE;
      end else begin
        op = (pick < 25) ? CMD_INSERT : (pick < 65) ? CMD_REMOVE :
             (pick < 95) ? CMD_QUERY : CMD_SPARE;
      end
      v = ($urandom_range(99) < 85) ? val_pool[$urandom_range(POOL_SIZE-1)] : $urandom;
      push_cmd(op, v);
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || s_valid) @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("%0d commands taken, %0d results checked, peak set size %0d",
             cmds_taken, results_seen, peak_cnt);
    $display("outcomes: %0d done, %0d duplicate, %0d full, %0d absent remove",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3]);
    if (fail_cnt == 0) begin
      $display("fixed_capacity_set_table_test passed");
    end else begin
      $display("fixed_capacity_set_table_test failed");
    end
    $finish;
  end

endmodule
